[hw/rtl/rfq_pkg.sv]
// shared types, constants and register codes of the tag read qualifier
package rfq_pkg;

   localparam int NUM_READERS     = 4;
   localparam int TAGS_PER_READER = 4;
   localparam int NUM_RULES       = 4;
   localparam int TAG_BITS        = 40;

   localparam int READER_W    = 2;
   localparam int SLOT_W      = 2;
   localparam int RULE_W      = 2;
   localparam int PAIR_W      = RULE_W + READER_W;
   localparam int ALLOW_DEPTH = NUM_READERS * TAGS_PER_READER;
   localparam int ALLOW_AW    = READER_W + SLOT_W;
   localparam int COUNT_W     = 16;
   localparam int SMALL_W     = 3;
   localparam int CFG_W       = 21;
   localparam int CSR_IDX_W   = 3;
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = 1;
   localparam int QFILL_W     = 2;

   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

   // rule word layout
   localparam int RW_READER_LSB = 16;
   localparam int RW_ALL_BIT    = 18;
   localparam int RW_ONCE_BIT   = 19;
   localparam int RW_ANY_BIT    = 20;

   localparam logic [CFG_W-1:0]   RULE_WORD_RESET   = 21'd786433;
   localparam logic [SMALL_W-1:0] RULE_COUNT_RESET  = 3'd0;
   localparam logic [SMALL_W-1:0] TAGS_IN_USE_RESET = 3'd4;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_RULE_COUNT  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_RULE_WORD_0 = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_RULE_WORD_1 = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_RULE_WORD_2 = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_RULE_WORD_3 = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_TAGS_IN_USE = 3'd5;

   // command codes
   localparam logic CMD_READING     = 1'b0;
   localparam logic CMD_ALLOW_WRITE = 1'b1;

   typedef enum logic [1:0] {
      OP_READ_EMPTY,
      OP_READ_TAG,
      OP_ALLOW_WRITE
   } op_kind_type;

   typedef struct packed {
      op_kind_type               kind;
      logic [READER_W-1:0]       reader;
      logic                      present;
      logic [TAG_BITS-1:0]       tag;
      logic [SLOT_W-1:0]         slot;
      logic                      eop;
   } op_type;

endpackage

[hw/rtl/rfq_ram.sv]
// generic single write port ram with registered read
module rfq_ram #(
   parameter int WIDTH = 40,
   parameter int DEPTH = 16
) (
   input  logic                                  clock,
   input  logic                                  wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                      wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                      rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[hw/rtl/rfq_front.sv]
// front end: classifies request beats and queues them for the back end
module rfq_front (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic                            req_command,
   input  logic [rfq_pkg::READER_W-1:0]    req_reader_index,
   input  logic                            req_tag_present,
   input  logic [rfq_pkg::TAG_BITS-1:0]    req_tag_id,
   input  logic [rfq_pkg::SLOT_W-1:0]      req_slot,
   input  logic                            req_end_of_poll,
   output logic                            op_valid,
   input  logic                            op_ready,
   output rfq_pkg::op_type                 op
);

   rfq_pkg::op_type             op_in;
   rfq_pkg::op_type             q_ff [rfq_pkg::QUEUE_DEPTH];
   logic [rfq_pkg::QPTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [rfq_pkg::QPTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [rfq_pkg::QFILL_W-1:0] fill_ff, fill_in;
   logic                        push, pop;

   always_comb begin
      op_in.kind    = (req_command == rfq_pkg::CMD_ALLOW_WRITE) ? rfq_pkg::OP_ALLOW_WRITE :
                      (req_tag_present ? rfq_pkg::OP_READ_TAG : rfq_pkg::OP_READ_EMPTY);
      op_in.reader  = req_reader_index;
      op_in.present = req_tag_present;
      op_in.tag     = req_tag_id;
      op_in.slot    = req_slot;
      op_in.eop     = req_end_of_poll;
   end

   assign req_ready = (fill_ff != rfq_pkg::QFILL_W'(rfq_pkg::QUEUE_DEPTH));
   assign op_valid  = (fill_ff != '0);
   assign op        = q_ff[rd_ptr_ff];
   assign push      = req_valid && req_ready;
   assign pop       = op_valid && op_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == rfq_pkg::QPTR_W'(rfq_pkg::QUEUE_DEPTH - 1)) ? '0 :
                     wr_ptr_ff + rfq_pkg::QPTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == rfq_pkg::QPTR_W'(rfq_pkg::QUEUE_DEPTH - 1)) ? '0 :
                     rd_ptr_ff + rfq_pkg::QPTR_W'(1);
      end
      if (push && !pop) begin
         fill_in = fill_ff + rfq_pkg::QFILL_W'(1);
      end else if (pop && !push) begin
         fill_in = fill_ff - rfq_pkg::QFILL_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
      if (push) begin
         q_ff[wr_ptr_ff] <= op_in;
      end
   end

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= rfq_pkg::QFILL_W'(rfq_pkg::QUEUE_DEPTH))
      else $error("queue fill beyond depth");

   a_fill_track: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> (fill_ff == $past(fill_ff) + rfq_pkg::QFILL_W'(1)))
      else $error("queue fill not advanced on push");

endmodule

[hw/rtl/rfq_back.sv]
// back end: reader state, allowlist, configuration and poll evaluation
module rfq_back (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            op_valid,
   output logic                            op_ready,
   input  rfq_pkg::op_type                 op,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [rfq_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [rfq_pkg::CFG_W-1:0]       csr_data,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic                            rsp_fired,
   output logic [rfq_pkg::RULE_W-1:0]      rsp_rule_index,
   output logic [rfq_pkg::READER_W-1:0]    rsp_out_reader,
   output logic [rfq_pkg::TAG_BITS-1:0]    rsp_out_tag,
   output logic                            rsp_last
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_RULES,
      ST_FLUSH
   } state_type;

   localparam int NR = rfq_pkg::NUM_READERS;
   localparam int TW = rfq_pkg::TAG_BITS;

   state_type state_ff, state_in;

   logic [rfq_pkg::SMALL_W-1:0] rule_count_ff, rule_count_in;
   logic [rfq_pkg::CFG_W-1:0]   rule_word_ff [rfq_pkg::NUM_RULES];
   logic [rfq_pkg::CFG_W-1:0]   rule_word_in [rfq_pkg::NUM_RULES];
   logic [rfq_pkg::SMALL_W-1:0] tags_in_use_ff, tags_in_use_in;

   logic [TW-1:0]               cur_tag_ff [NR];
   logic [TW-1:0]               cur_tag_in [NR];
   logic [NR-1:0]               held_ff, held_in;
   logic [rfq_pkg::COUNT_W-1:0] count_ff [NR];
   logic [rfq_pkg::COUNT_W-1:0] count_in [NR];
   logic [rfq_pkg::ALLOW_DEPTH-1:0] allow_valid_ff, allow_valid_in;

   logic [rfq_pkg::ALLOW_AW:0]   scan_cnt_ff, scan_cnt_in;
   logic                         cmp_vld_ff, cmp_vld_in;
   logic [rfq_pkg::ALLOW_AW-1:0] cmp_idx_ff, cmp_idx_in;
   logic [NR-1:0]                hit_ff, hit_in;
   logic [rfq_pkg::PAIR_W-1:0]   pair_ff, pair_in;

   logic                         pend_vld_ff, pend_vld_in;
   logic [rfq_pkg::RULE_W-1:0]   pend_rule_ff, pend_rule_in;
   logic [rfq_pkg::READER_W-1:0] pend_reader_ff, pend_reader_in;
   logic [TW-1:0]                pend_tag_ff, pend_tag_in;

   logic                         rsp_valid_ff, rsp_valid_in;
   logic                         rsp_fired_ff, rsp_fired_in;
   logic [rfq_pkg::RULE_W-1:0]   rsp_rule_ff, rsp_rule_in;
   logic [rfq_pkg::READER_W-1:0] rsp_reader_ff, rsp_reader_in;
   logic [TW-1:0]                rsp_tag_ff, rsp_tag_in;
   logic                         rsp_last_ff, rsp_last_in;

   logic                         ram_wr_en;
   logic [TW-1:0]                ram_rd_data;

   logic [rfq_pkg::SMALL_W-1:0]  rules_used, slots_used;
   logic [rfq_pkg::READER_W-1:0] cmp_reader;
   logic [rfq_pkg::SLOT_W-1:0]   cmp_slot;
   logic                         slot_hit;
   logic [rfq_pkg::RULE_W-1:0]   pair_rule;
   logic [rfq_pkg::READER_W-1:0] pair_reader;
   logic                         pair_last;
   logic [rfq_pkg::CFG_W-1:0]    word;
   logic [rfq_pkg::COUNT_W-1:0]  min_reads, pair_count;
   logic                         fire;
   logic                         out_free;

   assign csr_ready = 1'b1;

   assign ram_wr_en = (state_ff == ST_IDLE) && op_valid && (op.kind == rfq_pkg::OP_ALLOW_WRITE);

   rfq_ram #(
      .WIDTH(rfq_pkg::TAG_BITS),
      .DEPTH(rfq_pkg::ALLOW_DEPTH)
   ) u_allow_ram (
      .clock  (clock),
      .wr_en  (ram_wr_en),
      .wr_addr({op.reader, op.slot}),
      .wr_data(op.tag),
      .rd_addr(scan_cnt_ff[rfq_pkg::ALLOW_AW-1:0]),
      .rd_data(ram_rd_data)
   );

   // clamped counts
   assign rules_used = (rule_count_ff > rfq_pkg::SMALL_W'(rfq_pkg::NUM_RULES)) ?
                       rfq_pkg::SMALL_W'(rfq_pkg::NUM_RULES) : rule_count_ff;
   assign slots_used = (tags_in_use_ff > rfq_pkg::SMALL_W'(rfq_pkg::TAGS_PER_READER)) ?
                       rfq_pkg::SMALL_W'(rfq_pkg::TAGS_PER_READER) : tags_in_use_ff;

   // allowlist scan compare
   assign cmp_reader = cmp_idx_ff[rfq_pkg::ALLOW_AW-1:rfq_pkg::SLOT_W];
   assign cmp_slot   = cmp_idx_ff[rfq_pkg::SLOT_W-1:0];
   assign slot_hit   = allow_valid_ff[cmp_idx_ff] && held_ff[cmp_reader] &&
                       ({1'b0, cmp_slot} < slots_used) &&
                       (ram_rd_data == cur_tag_ff[cmp_reader]);

   // rule and reader pair check
   assign pair_rule   = pair_ff[rfq_pkg::PAIR_W-1:rfq_pkg::READER_W];
   assign pair_reader = pair_ff[rfq_pkg::READER_W-1:0];
   assign pair_last   = (pair_reader == rfq_pkg::READER_W'(NR - 1)) &&
                        ({1'b0, pair_rule} == rules_used - rfq_pkg::SMALL_W'(1));
   assign word        = rule_word_ff[pair_rule];
   assign min_reads   = word[rfq_pkg::COUNT_W-1:0];
   assign pair_count  = count_ff[pair_reader];
   assign fire = (word[rfq_pkg::RW_ALL_BIT] ||
                  (word[rfq_pkg::RW_READER_LSB +: rfq_pkg::READER_W] == pair_reader)) &&
                 (pair_count >= min_reads) &&
                 !(word[rfq_pkg::RW_ONCE_BIT] && (pair_count > min_reads)) &&
                 (word[rfq_pkg::RW_ANY_BIT] || hit_ff[pair_reader]);

   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in       = state_ff;
      rule_count_in  = rule_count_ff;
      rule_word_in   = rule_word_ff;
      tags_in_use_in = tags_in_use_ff;
      cur_tag_in     = cur_tag_ff;
      held_in        = held_ff;
      count_in       = count_ff;
      allow_valid_in = allow_valid_ff;
      scan_cnt_in    = scan_cnt_ff;
      cmp_vld_in     = 1'b0;
      cmp_idx_in     = cmp_idx_ff;
      hit_in         = hit_ff;
      pair_in        = pair_ff;
      pend_vld_in    = pend_vld_ff;
      pend_rule_in   = pend_rule_ff;
      pend_reader_in = pend_reader_ff;
      pend_tag_in    = pend_tag_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_fired_in   = rsp_fired_ff;
      rsp_rule_in    = rsp_rule_ff;
      rsp_reader_in  = rsp_reader_ff;
      rsp_tag_in     = rsp_tag_ff;
      rsp_last_in    = rsp_last_ff;
      op_ready       = 1'b0;

      if (csr_valid) begin
         case (csr_index)
            rfq_pkg::CSR_RULE_COUNT:  rule_count_in   = csr_data[rfq_pkg::SMALL_W-1:0];
            rfq_pkg::CSR_RULE_WORD_0: rule_word_in[0] = csr_data;
            rfq_pkg::CSR_RULE_WORD_1: rule_word_in[1] = csr_data;
            rfq_pkg::CSR_RULE_WORD_2: rule_word_in[2] = csr_data;
            rfq_pkg::CSR_RULE_WORD_3: rule_word_in[3] = csr_data;
            rfq_pkg::CSR_TAGS_IN_USE: tags_in_use_in  = csr_data[rfq_pkg::SMALL_W-1:0];
            default: ;
         endcase
      end

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            op_ready = 1'b1;
            if (op_valid) begin
               case (op.kind)
                  rfq_pkg::OP_READ_EMPTY: begin
                     cur_tag_in[op.reader] = '0;
                     held_in[op.reader]    = 1'b0;
                     count_in[op.reader]   = '0;
                  end
                  rfq_pkg::OP_READ_TAG: begin
                     if (held_ff[op.reader] && (cur_tag_ff[op.reader] == op.tag)) begin
                        if (count_ff[op.reader] != rfq_pkg::COUNT_MAX) begin
                           count_in[op.reader] = count_ff[op.reader] +
                                                 rfq_pkg::COUNT_W'(1);
                        end
                     end else begin
                        cur_tag_in[op.reader] = op.tag;
                        held_in[op.reader]    = 1'b1;
                        count_in[op.reader]   = rfq_pkg::COUNT_W'(1);
                     end
                  end
                  rfq_pkg::OP_ALLOW_WRITE: begin
                     allow_valid_in[{op.reader, op.slot}] = op.present;
                  end
                  default: ;
               endcase
               if (op.eop) begin
                  state_in    = ST_SCAN;
                  scan_cnt_in = '0;
                  hit_in      = '0;
               end
            end
         end
         ST_SCAN: begin
            if (scan_cnt_ff < (rfq_pkg::ALLOW_AW + 1)'(rfq_pkg::ALLOW_DEPTH)) begin
               cmp_vld_in  = 1'b1;
               cmp_idx_in  = scan_cnt_ff[rfq_pkg::ALLOW_AW-1:0];
               scan_cnt_in = scan_cnt_ff + (rfq_pkg::ALLOW_AW + 1)'(1);
            end
            if (cmp_vld_ff) begin
               if (slot_hit) begin
                  hit_in[cmp_reader] = 1'b1;
               end
               if (cmp_idx_ff == rfq_pkg::ALLOW_AW'(rfq_pkg::ALLOW_DEPTH - 1)) begin
                  cmp_vld_in = 1'b0;
                  pair_in    = '0;
                  state_in   = (rules_used == '0) ? ST_FLUSH : ST_RULES;
               end
            end
         end
         ST_RULES: begin
            if (!fire || !pend_vld_ff || out_free) begin
               if (fire) begin
                  if (pend_vld_ff) begin
                     rsp_valid_in  = 1'b1;
                     rsp_fired_in  = 1'b1;
                     rsp_rule_in   = pend_rule_ff;
                     rsp_reader_in = pend_reader_ff;
                     rsp_tag_in    = pend_tag_ff;
                     rsp_last_in   = 1'b0;
                  end
                  pend_vld_in    = 1'b1;
                  pend_rule_in   = pair_rule;
                  pend_reader_in = pair_reader;
                  pend_tag_in    = cur_tag_ff[pair_reader];
               end
               if (pair_last) begin
                  state_in = ST_FLUSH;
               end else begin
                  pair_in = pair_ff + rfq_pkg::PAIR_W'(1);
               end
            end
         end
         ST_FLUSH: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_fired_in  = pend_vld_ff;
               rsp_rule_in   = pend_vld_ff ? pend_rule_ff : '0;
               rsp_reader_in = pend_vld_ff ? pend_reader_ff : '0;
               rsp_tag_in    = pend_vld_ff ? pend_tag_ff : '0;
               rsp_last_in   = 1'b1;
               pend_vld_in   = 1'b0;
               state_in      = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         rule_count_ff  <= rfq_pkg::RULE_COUNT_RESET;
         rule_word_ff   <= '{default: rfq_pkg::RULE_WORD_RESET};
         tags_in_use_ff <= rfq_pkg::TAGS_IN_USE_RESET;
         cur_tag_ff     <= '{default: '0};
         held_ff        <= '0;
         count_ff       <= '{default: '0};
         allow_valid_ff <= '0;
         scan_cnt_ff    <= '0;
         cmp_vld_ff     <= 1'b0;
         hit_ff         <= '0;
         pair_ff        <= '0;
         pend_vld_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         rule_count_ff  <= rule_count_in;
         rule_word_ff   <= rule_word_in;
         tags_in_use_ff <= tags_in_use_in;
         cur_tag_ff     <= cur_tag_in;
         held_ff        <= held_in;
         count_ff       <= count_in;
         allow_valid_ff <= allow_valid_in;
         scan_cnt_ff    <= scan_cnt_in;
         cmp_vld_ff     <= cmp_vld_in;
         hit_ff         <= hit_in;
         pair_ff        <= pair_in;
         pend_vld_ff    <= pend_vld_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
      cmp_idx_ff     <= cmp_idx_in;
      pend_rule_ff   <= pend_rule_in;
      pend_reader_ff <= pend_reader_in;
      pend_tag_ff    <= pend_tag_in;
      rsp_fired_ff   <= rsp_fired_in;
      rsp_rule_ff    <= rsp_rule_in;
      rsp_reader_ff  <= rsp_reader_in;
      rsp_tag_ff     <= rsp_tag_in;
      rsp_last_ff    <= rsp_last_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_fired      = rsp_fired_ff;
   assign rsp_rule_index = rsp_rule_ff;
   assign rsp_out_reader = rsp_reader_ff;
   assign rsp_out_tag    = rsp_tag_ff;
   assign rsp_last       = rsp_last_ff;

   a_pend_in_walk: assert property (@(posedge clock) disable iff (reset)
      pend_vld_ff |-> (state_ff == ST_RULES || state_ff == ST_FLUSH))
      else $error("pending firing outside rule walk");

   a_nofire_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_fired_ff) |-> rsp_last_ff)
      else $error("non-fired result without last");

   a_flush_loads: assert property (@(posedge clock) disable iff (reset)
      ($past(!reset) && state_ff == ST_IDLE && $past(state_ff) == ST_FLUSH)
      |-> (rsp_valid_ff && rsp_last_ff))
      else $error("poll closed without final result");

   a_cmp_in_scan: assert property (@(posedge clock) disable iff (reset)
      cmp_vld_ff |-> (state_ff == ST_SCAN))
      else $error("allowlist compare outside scan");

endmodule

[hw/rtl/rfid_tag_read_qualifier_top.sv]
// top level of the tag read qualifier
//
// req channel: one beat is a reader reading or an allowlist write, with
// req_end_of_poll set on the last beat of a poll. beats enter a two-entry
// queue, so up to two more beats are taken while the back end works on a poll.
// csr channel: register writes by index, always ready; write only while idle.
// rsp channel: one beat per rule and reader pair that fires, in rule order then
// reader order, or one non-fired beat; rsp_last marks the final beat of a poll.
// the back end takes beats only while idle; a beat with end of poll then goes
// through an update, an allowlist scan through the ram read port, a rule walk
// over every reader of each rule in use (skipped when no rule is in use) and
// a flush, and the back end takes its next beat once the flush is done.
// the rule walk holds on a firing pair while a firing is pending, the output
// register is full and rsp_ready is low; the flush waits for a free register.
// reset clears reader state, allowlist valid bits and all handshake state and
// sets the configuration to its reset values; no clearing pass is needed.
module rfid_tag_read_qualifier_top (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic                            req_command,
   input  logic [rfq_pkg::READER_W-1:0]    req_reader_index,
   input  logic                            req_tag_present,
   input  logic [rfq_pkg::TAG_BITS-1:0]    req_tag_id,
   input  logic [rfq_pkg::SLOT_W-1:0]      req_slot,
   input  logic                            req_end_of_poll,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [rfq_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [rfq_pkg::CFG_W-1:0]       csr_data,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic                            rsp_fired,
   output logic [rfq_pkg::RULE_W-1:0]      rsp_rule_index,
   output logic [rfq_pkg::READER_W-1:0]    rsp_out_reader,
   output logic [rfq_pkg::TAG_BITS-1:0]    rsp_out_tag,
   output logic                            rsp_last
);

   logic            op_valid;
   logic            op_ready;
   rfq_pkg::op_type op;

   rfq_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_command     (req_command),
      .req_reader_index(req_reader_index),
      .req_tag_present (req_tag_present),
      .req_tag_id      (req_tag_id),
      .req_slot        (req_slot),
      .req_end_of_poll (req_end_of_poll),
      .op_valid        (op_valid),
      .op_ready        (op_ready),
      .op              (op)
   );

   rfq_back u_back (
      .clock         (clock),
      .reset         (reset),
      .op_valid      (op_valid),
      .op_ready      (op_ready),
      .op            (op),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_data      (csr_data),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_fired     (rsp_fired),
      .rsp_rule_index(rsp_rule_index),
      .rsp_out_reader(rsp_out_reader),
      .rsp_out_tag   (rsp_out_tag),
      .rsp_last      (rsp_last)
   );

endmodule

[tb/sv/rfid_tag_read_qualifier_checker.sv]
// checker of the tag read qualifier: reader state, poll prediction, rsp beat compare
module rfid_tag_read_qualifier_checker (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   input  logic                            req_ready,
   input  logic                            req_command,
   input  logic [rfq_pkg::READER_W-1:0]    req_reader_index,
   input  logic                            req_tag_present,
   input  logic [rfq_pkg::TAG_BITS-1:0]    req_tag_id,
   input  logic [rfq_pkg::SLOT_W-1:0]      req_slot,
   input  logic                            req_end_of_poll,
   input  logic                            csr_valid,
   input  logic                            csr_ready,
   input  logic [rfq_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [rfq_pkg::CFG_W-1:0]       csr_data,
   input  logic                            rsp_valid,
   input  logic                            rsp_ready,
   input  logic                            rsp_fired,
   input  logic [rfq_pkg::RULE_W-1:0]      rsp_rule_index,
   input  logic [rfq_pkg::READER_W-1:0]    rsp_out_reader,
   input  logic [rfq_pkg::TAG_BITS-1:0]    rsp_out_tag,
   input  logic                            rsp_last,
   output int                              errors,
   output int                              outstanding,
   output int                              beats_in,
   output int                              results_seen,
   output int                              firings_seen
);

   typedef struct packed {
      logic                         fired;
      logic [rfq_pkg::RULE_W-1:0]   rule;
      logic [rfq_pkg::READER_W-1:0] reader;
      logic [rfq_pkg::TAG_BITS-1:0] tag;
      logic                         last;
   } poll_result_type;

   poll_result_type pending_results[$];

   logic [rfq_pkg::SMALL_W-1:0]  rules_used;
   logic [rfq_pkg::CFG_W-1:0]    rule_cfg [rfq_pkg::NUM_RULES];
   logic [rfq_pkg::SMALL_W-1:0]  slots_used;

   logic [rfq_pkg::TAG_BITS-1:0] cur_tag    [rfq_pkg::NUM_READERS];
   logic                         tag_held   [rfq_pkg::NUM_READERS];
   logic [rfq_pkg::COUNT_W-1:0]  read_count [rfq_pkg::NUM_READERS];
   logic [rfq_pkg::TAG_BITS-1:0] allow_tag  [rfq_pkg::ALLOW_DEPTH];
   logic                         allow_valid[rfq_pkg::ALLOW_DEPTH];

   function automatic logic tag_allowed(int rd);
      int n;
      int e;
      n = (slots_used > rfq_pkg::TAGS_PER_READER) ? rfq_pkg::TAGS_PER_READER :
          int'(slots_used);
      if (!tag_held[rd]) return 1'b0;
      for (int s = 0; s < n; s++) begin
         e = rd * rfq_pkg::TAGS_PER_READER + s;
         if (allow_valid[e] && allow_tag[e] == cur_tag[rd]) return 1'b1;
      end
      return 1'b0;
   endfunction

   function automatic logic rule_fires(logic [rfq_pkg::CFG_W-1:0] w, int rd);
      logic [rfq_pkg::COUNT_W-1:0] min_reads;
      min_reads = w[rfq_pkg::COUNT_W-1:0];
      if (!w[rfq_pkg::RW_ALL_BIT] &&
          int'(w[rfq_pkg::RW_READER_LSB +: rfq_pkg::READER_W]) != rd) return 1'b0;
      if (read_count[rd] < min_reads) return 1'b0;
      if (w[rfq_pkg::RW_ONCE_BIT] && read_count[rd] > min_reads) return 1'b0;
      return w[rfq_pkg::RW_ANY_BIT] || tag_allowed(rd);
   endfunction

   task automatic update_reader_state();
      int rd;
      int e;
      rd = int'(req_reader_index);
      if (req_command == rfq_pkg::CMD_ALLOW_WRITE) begin
         e = rd * rfq_pkg::TAGS_PER_READER + int'(req_slot);
         allow_tag[e]   = req_tag_id;
         allow_valid[e] = req_tag_present;
      end else if (!req_tag_present) begin
         cur_tag[rd]    = '0;
         tag_held[rd]   = 1'b0;
         read_count[rd] = '0;
      end else if (tag_held[rd] && cur_tag[rd] == req_tag_id) begin
         if (read_count[rd] != rfq_pkg::COUNT_MAX) read_count[rd] = read_count[rd] + 1'b1;
      end else begin
         cur_tag[rd]    = req_tag_id;
         tag_held[rd]   = 1'b1;
         read_count[rd] = rfq_pkg::COUNT_W'(1);
      end
   endtask

   task automatic evaluate_poll();
      int nr;
      int k;
      logic have;
      poll_result_type item;
      nr   = (rules_used > rfq_pkg::NUM_RULES) ? rfq_pkg::NUM_RULES : int'(rules_used);
      k    = 0;
      have = 1'b0;
      item = '0;
      for (int r = 0; r < nr; r++) begin
         for (int i = 0; i < rfq_pkg::NUM_READERS; i++) begin
            if (k < 16 && rule_fires(rule_cfg[r], i)) begin
               if (have) pending_results.push_back(item);
               item.fired  = 1'b1;
               item.rule   = rfq_pkg::RULE_W'(r);
               item.reader = rfq_pkg::READER_W'(i);
               item.tag    = cur_tag[i];
               item.last   = 1'b0;
               have = 1'b1;
               k++;
            end
         end
      end
      if (!have) item = '0;
      item.last = 1'b1;
      pending_results.push_back(item);
   endtask

   always @(posedge clock) begin
      poll_result_type got;
      poll_result_type want;
      if (reset) begin
         pending_results.delete();
         rules_used = rfq_pkg::RULE_COUNT_RESET;
         slots_used = rfq_pkg::TAGS_IN_USE_RESET;
         for (int r = 0; r < rfq_pkg::NUM_RULES; r++) rule_cfg[r] = rfq_pkg::RULE_WORD_RESET;
         for (int i = 0; i < rfq_pkg::NUM_READERS; i++) begin
            cur_tag[i]    = '0;
            tag_held[i]   = 1'b0;
            read_count[i] = '0;
         end
         for (int e = 0; e < rfq_pkg::ALLOW_DEPTH; e++) begin
            allow_tag[e]   = '0;
            allow_valid[e] = 1'b0;
         end
         errors       = 0;
         beats_in     = 0;
         results_seen = 0;
         firings_seen = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            got.fired  = rsp_fired;
            got.rule   = rsp_rule_index;
            got.reader = rsp_out_reader;
            got.tag    = rsp_out_tag;
            got.last   = rsp_last;
            results_seen++;
            if (rsp_fired === 1'b1) firings_seen++;
            if (pending_results.size() == 0) begin
               errors++;
               $display("%0t: result beat with nothing expected", $time);
               $display("%0t:   actual fired=%0d rule=%0d reader=%0d tag=%h last=%0d",
                        $time, got.fired, got.rule, got.reader, got.tag, got.last);
            end else begin
               want = pending_results.pop_front();
               if (got !== want) begin
                  errors++;
                  $display("%0t: result mismatch", $time);
                  $display("%0t:   expected fired=%0d rule=%0d reader=%0d tag=%h last=%0d",
                           $time, want.fired, want.rule, want.reader, want.tag, want.last);
                  $display("%0t:   actual   fired=%0d rule=%0d reader=%0d tag=%h last=%0d",
                           $time, got.fired, got.rule, got.reader, got.tag, got.last);
               end
            end
         end
         if (req_valid && req_ready) begin
            beats_in++;
            update_reader_state();
            if (req_end_of_poll) evaluate_poll();
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               rfq_pkg::CSR_RULE_COUNT:  rules_used  = csr_data[rfq_pkg::SMALL_W-1:0];
               rfq_pkg::CSR_RULE_WORD_0: rule_cfg[0] = csr_data;
               rfq_pkg::CSR_RULE_WORD_1: rule_cfg[1] = csr_data;
               rfq_pkg::CSR_RULE_WORD_2: rule_cfg[2] = csr_data;
               rfq_pkg::CSR_RULE_WORD_3: rule_cfg[3] = csr_data;
               rfq_pkg::CSR_TAGS_IN_USE: slots_used  = csr_data[rfq_pkg::SMALL_W-1:0];
               default: ;
            endcase
         end
      end
      outstanding = pending_results.size();
   end

endmodule

[tb/sv/rfid_tag_read_qualifier_top_tb.sv]
// regression top of the tag read qualifier: clock, reset, stimulus, receiver and verdict
module rfid_tag_read_qualifier_top_tb;

   localparam int CYCLE_LIMIT   = 1_000_000;
   localparam int SETTLE_CYCLES = 64;
   localparam int STALL_CYCLES  = 400;
   localparam int RANDOM_STEP   = 44;

   localparam logic [rfq_pkg::CSR_IDX_W-1:0] CSR_SPARE_LO = 3'd6;
   localparam logic [rfq_pkg::CSR_IDX_W-1:0] CSR_SPARE_HI = 3'd7;

   localparam logic [rfq_pkg::TAG_BITS-1:0] TAG_ZERO = '0;
   localparam logic [rfq_pkg::TAG_BITS-1:0] TAG_ONES = '1;
   localparam logic [rfq_pkg::TAG_BITS-1:0] TAG_A    = 40'h5A_C3E1_0F96;
   localparam logic [rfq_pkg::TAG_BITS-1:0] TAG_B    = 40'hA5_3C1E_F069;

   logic                           clock            = 1'b0;
   logic                           reset            = 1'b1;
   logic                           req_valid        = 1'b0;
   logic                           req_ready;
   logic                           req_command      = rfq_pkg::CMD_READING;
   logic [rfq_pkg::READER_W-1:0]   req_reader_index = '0;
   logic                           req_tag_present  = 1'b0;
   logic [rfq_pkg::TAG_BITS-1:0]   req_tag_id       = '0;
   logic [rfq_pkg::SLOT_W-1:0]     req_slot         = '0;
   logic                           req_end_of_poll  = 1'b0;
   logic                           csr_valid        = 1'b0;
   logic                           csr_ready;
   logic [rfq_pkg::CSR_IDX_W-1:0]  csr_index        = '0;
   logic [rfq_pkg::CFG_W-1:0]      csr_data         = '0;
   logic                           rsp_valid;
   logic                           rsp_ready        = 1'b0;
   logic                           rsp_fired;
   logic [rfq_pkg::RULE_W-1:0]     rsp_rule_index;
   logic [rfq_pkg::READER_W-1:0]   rsp_out_reader;
   logic [rfq_pkg::TAG_BITS-1:0]   rsp_out_tag;
   logic                           rsp_last;

   int errors;
   int outstanding;
   int beats_in;
   int results_seen;
   int firings_seen;

   int send_idle_pct = 13;
   int recv_idle_pct = 70;
   bit stall_request = 1'b0;
   int stall_left    = 0;
   int cycle_count   = 0;
   int random_sent   = 0;
   logic [rfq_pkg::TAG_BITS-1:0] tag_pool [4];

   rfid_tag_read_qualifier_top dut (.*);

   rfid_tag_read_qualifier_checker qualifier_check (.*);

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   // receiver: random back-pressure, or a long hold-off on request
   initial begin
      forever begin
         @(negedge clock);
         if (stall_request) begin
            stall_request = 1'b0;
            stall_left    = STALL_CYCLES;
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   function automatic logic [rfq_pkg::TAG_BITS-1:0] rand_tag();
      return rfq_pkg::TAG_BITS'({$urandom(), $urandom()});
   endfunction

   function automatic logic [rfq_pkg::CFG_W-1:0] mix_small(int v);
      return (rfq_pkg::CFG_W'($urandom()) & ~rfq_pkg::CFG_W'(7)) | rfq_pkg::CFG_W'(v);
   endfunction

   function automatic logic [rfq_pkg::CFG_W-1:0] random_rule();
      logic [rfq_pkg::CFG_W-1:0] w;
      w = rfq_pkg::CFG_W'($urandom());
      if ($urandom_range(99) < 85) w[rfq_pkg::COUNT_W-1:0] = rfq_pkg::COUNT_W'($urandom_range(4));
      return w;
   endfunction

   task automatic put_req(input logic cmd, input logic [rfq_pkg::READER_W-1:0] rd,
                          input logic present, input logic [rfq_pkg::TAG_BITS-1:0] tag,
                          input logic [rfq_pkg::SLOT_W-1:0] slot, input logic eop);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid        <= 1'b1;
      req_command      <= cmd;
      req_reader_index <= rd;
      req_tag_present  <= present;
      req_tag_id       <= tag;
      req_slot         <= slot;
      req_end_of_poll  <= eop;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic write_csr(input logic [rfq_pkg::CSR_IDX_W-1:0] idx,
                            input logic [rfq_pkg::CFG_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b0;
      @(negedge clock);
   endtask

   // stop sending, drain every expected beat, then let the back end go quiet
   task automatic settle();
      req_valid <= 1'b0;
      while (outstanding != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic randomize_config();
      int rc;
      int tu;
      rc = ($urandom_range(99) < 60) ? rfq_pkg::NUM_RULES : int'($urandom_range(7));
      tu = ($urandom_range(99) < 60) ? rfq_pkg::TAGS_PER_READER : int'($urandom_range(7));
      write_csr(rfq_pkg::CSR_RULE_COUNT, mix_small(rc));
      write_csr(rfq_pkg::CSR_RULE_WORD_0, random_rule());
      write_csr(rfq_pkg::CSR_RULE_WORD_1, random_rule());
      write_csr(rfq_pkg::CSR_RULE_WORD_2, random_rule());
      write_csr(rfq_pkg::CSR_RULE_WORD_3, random_rule());
      write_csr(rfq_pkg::CSR_TAGS_IN_USE, mix_small(tu));
      for (int i = 0; i < 4; i++) tag_pool[i] = rand_tag();
   endtask

   // mostly polls of repeated readings, some allowlist loads, some noise
   task automatic random_poll();
      int n;
      int pick;
      int rd;
      logic noise;
      logic eop;
      n     = $urandom_range(1, 6);
      noise = ($urandom_range(99) < 15);
      for (int j = 0; j < n; j++) begin
         eop  = (j == n - 1);
         pick = $urandom_range(99);
         rd   = $urandom_range(3);
         if (noise) begin
            put_req(1'($urandom_range(1)), rfq_pkg::READER_W'(rd), 1'($urandom_range(1)),
                    rand_tag(), rfq_pkg::SLOT_W'($urandom_range(3)),
                    eop | 1'($urandom_range(1)));
         end else if (pick < 14) begin
            put_req(rfq_pkg::CMD_ALLOW_WRITE, rfq_pkg::READER_W'(rd), ($urandom_range(9) != 0),
                    tag_pool[$urandom_range(3)], rfq_pkg::SLOT_W'($urandom_range(3)), eop);
         end else if (pick < 22) begin
            put_req(rfq_pkg::CMD_READING, rfq_pkg::READER_W'(rd), 1'b0, rand_tag(),
                    rfq_pkg::SLOT_W'($urandom_range(3)), eop);
         end else begin
            put_req(rfq_pkg::CMD_READING, rfq_pkg::READER_W'(rd), 1'b1,
                    ($urandom_range(99) < 80) ? tag_pool[rd] : tag_pool[$urandom_range(3)],
                    rfq_pkg::SLOT_W'($urandom_range(3)), eop);
         end
      end
      random_sent += n;
   endtask

   initial begin
      logic [rfq_pkg::TAG_BITS-1:0] tag;
      logic present;
      for (int i = 0; i < 4; i++) tag_pool[i] = rand_tag();
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      write_csr(rfq_pkg::CSR_RULE_COUNT, mix_small(rfq_pkg::NUM_RULES));
      write_csr(rfq_pkg::CSR_RULE_WORD_0, 21'h140000);
      write_csr(rfq_pkg::CSR_RULE_WORD_1, 21'h1FFFFF);
      write_csr(rfq_pkg::CSR_RULE_WORD_2, 21'h000000);
      write_csr(rfq_pkg::CSR_RULE_WORD_3, 21'h090002);
      write_csr(rfq_pkg::CSR_TAGS_IN_USE, 21'h000004);
      write_csr(CSR_SPARE_LO, rfq_pkg::CFG_W'($urandom()));
      write_csr(CSR_SPARE_HI, rfq_pkg::CFG_W'($urandom()));

      // load every allowlist slot before the first poll, last write ends a poll
      for (int r = 0; r < rfq_pkg::NUM_READERS; r++) begin
         for (int s = 0; s < rfq_pkg::TAGS_PER_READER; s++) begin
            case (s)
               0:       tag = r[0] ? TAG_B : TAG_ONES;
               1:       tag = TAG_ZERO;
               default: tag = rand_tag();
            endcase
            present = (s < 2) ? 1'b1 : 1'($urandom_range(1));
            put_req(rfq_pkg::CMD_ALLOW_WRITE, rfq_pkg::READER_W'(r), present, tag,
                    rfq_pkg::SLOT_W'(s), (r == 3 && s == 3));
         end
      end
      put_req(rfq_pkg::CMD_READING, 0, 1'b1, TAG_ONES, 0, 1'b0);
      put_req(rfq_pkg::CMD_READING, 1, 1'b1, TAG_B, 1, 1'b0);
      put_req(rfq_pkg::CMD_READING, 1, 1'b1, TAG_B, 2, 1'b0);
      put_req(rfq_pkg::CMD_READING, 2, 1'b0, TAG_ONES, 3, 1'b0);
      put_req(rfq_pkg::CMD_READING, 3, 1'b1, TAG_ZERO, 0, 1'b1);
      put_req(rfq_pkg::CMD_READING, 1, 1'b1, TAG_B, 0, 1'b1);
      put_req(rfq_pkg::CMD_ALLOW_WRITE, 0, 1'b0, TAG_ONES, 0, 1'b1);

      settle();
      write_csr(rfq_pkg::CSR_RULE_COUNT, 21'h000007);
      write_csr(rfq_pkg::CSR_RULE_WORD_2, 21'h020000);
      write_csr(rfq_pkg::CSR_TAGS_IN_USE, 21'h000007);
      put_req(rfq_pkg::CMD_READING, 3, 1'b1, TAG_ZERO, 0, 1'b1);

      settle();
      write_csr(rfq_pkg::CSR_RULE_COUNT, mix_small(0));
      put_req(rfq_pkg::CMD_READING, 2, 1'b1, TAG_A, 0, 1'b1);

      // every rule fires for every reader
      settle();
      write_csr(rfq_pkg::CSR_RULE_COUNT, 21'h000004);
      write_csr(rfq_pkg::CSR_RULE_WORD_0, 21'h140000);
      write_csr(rfq_pkg::CSR_RULE_WORD_1, 21'h140000);
      write_csr(rfq_pkg::CSR_RULE_WORD_2, 21'h140000);
      write_csr(rfq_pkg::CSR_RULE_WORD_3, 21'h140000);
      write_csr(rfq_pkg::CSR_TAGS_IN_USE, 21'h000000);
      put_req(rfq_pkg::CMD_READING, 1, 1'b0, TAG_A, 0, 1'b0);
      put_req(rfq_pkg::CMD_READING, 1, 1'b1, TAG_B, 0, 1'b0);
      put_req(rfq_pkg::CMD_READING, 1, 1'b1, TAG_B, 0, 1'b1);

      for (int ph = 0; ph < 3; ph++) begin
         settle();
         case (ph)
            0: begin
               send_idle_pct = 13;
               recv_idle_pct = 70;
            end
            1: begin
               send_idle_pct = 70;
               recv_idle_pct = 13;
            end
            default: begin
               send_idle_pct = 0;
               recv_idle_pct = 0;
            end
         endcase
         randomize_config();
         while (random_sent < RANDOM_STEP * (ph + 1)) random_poll();
      end

      // hold the receiver off while polls keep coming, so the input backs up
      stall_request = 1'b1;
      repeat (10) begin
         put_req(rfq_pkg::CMD_READING, rfq_pkg::READER_W'($urandom_range(3)), 1'b1,
                 tag_pool[$urandom_range(3)], rfq_pkg::SLOT_W'($urandom_range(3)), 1'b1);
      end
      settle();

      $display("summary: %0d request beats, %0d result beats, %0d of them firings",
               beats_in, results_seen, firings_seen);
      $display("summary: directed polls, three idle mixes and a %0d-cycle receiver hold-off",
               STALL_CYCLES);
      if (errors == 0 && outstanding == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
